[hdl/i2cmbe_pkg.sv]
// shared types, constants and helpers for the i2c master bit engine
`default_nettype none

package i2cmbe_pkg;

  // phase counter width and its saturation value
  localparam int unsigned CntW = 16;
  localparam logic [CntW-1:0] CntMax = '1;

  // configuration port
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ToW     = 8;

  localparam logic [CfgIdxW-1:0] CfgStartStopHold = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgBitPhase      = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAckTimeout    = 2'd2;

  // reset values of the configuration registers
  localparam logic [CfgW-1:0] HoldRst    = 16'd4;
  localparam logic [CfgW-1:0] BitRst     = 16'd2;
  localparam logic [ToW-1:0]  TimeoutRst = 8'd250;

  // raw request codes on the input
  localparam logic [2:0] ReqStart = 3'd1;
  localparam logic [2:0] ReqStop  = 3'd2;
  localparam logic [2:0] ReqWrite = 3'd3;
  localparam logic [2:0] ReqRead  = 3'd4;
  localparam logic [2:0] ReqWait  = 3'd5;

  typedef enum logic [2:0] {
    CmdNone,
    CmdStart,
    CmdStop,
    CmdWrite,
    CmdRead,
    CmdWait
  } cmd_e;

  typedef struct packed {
    logic [2:0] req_type;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } in_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_pull_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_failed;
  } out_t;

  // classified tick as held in the queue
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] tx_byte;
    logic       send_ack;
    logic       sda_in;
  } tick_t;

  // phase length from a register: zero acts as one, large values saturate
  function automatic logic [CntW-1:0] load_len(logic [CfgW-1:0] v);
    logic [31:0] v32;
    logic [CntW-1:0] len;
    v32 = 32'(v);
    if (v32 == 32'd0) begin
      len = CntW'(1);
    end else if (v32 > 32'(CntMax)) begin
      len = CntMax;
    end else begin
      len = CntW'(v32);
    end
    return len;
  endfunction

endpackage

`default_nettype wire

[hdl/i2cmbe_front.sv]
// front end: takes input transactions and classifies the request
`default_nettype none

module i2cmbe_front (
  input  wire  i2cmbe_pkg::in_t   in_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    q_full_i,
  output logic                    push_o,
  output i2cmbe_pkg::tick_t       push_data_o
);

  i2cmbe_pkg::cmd_e cmd;

  always_comb begin
    case (in_data_i.req_type)
      i2cmbe_pkg::ReqStart: cmd = i2cmbe_pkg::CmdStart;
      i2cmbe_pkg::ReqStop:  cmd = i2cmbe_pkg::CmdStop;
      i2cmbe_pkg::ReqWrite: cmd = i2cmbe_pkg::CmdWrite;
      i2cmbe_pkg::ReqRead:  cmd = i2cmbe_pkg::CmdRead;
      i2cmbe_pkg::ReqWait:  cmd = i2cmbe_pkg::CmdWait;
      // no request and the unused codes all mean a plain tick
      default:              cmd = i2cmbe_pkg::CmdNone;
    endcase
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    push_data_o.cmd      = cmd;
    push_data_o.tx_byte  = in_data_i.tx_byte;
    push_data_o.send_ack = in_data_i.send_ack;
    push_data_o.sda_in   = in_data_i.sda_in;
  end

endmodule

`default_nettype wire

[hdl/i2cmbe_queue.sv]
// two-entry queue between the classifier and the bus engine
`default_nettype none

module i2cmbe_queue (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  i2cmbe_pkg::tick_t       push_data_i,
  output logic                    full_o,
  output logic                    pop_valid_o,
  input  logic                    pop_i,
  output i2cmbe_pkg::tick_t       pop_data_o
);

  i2cmbe_pkg::tick_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o      = cnt_q == 2'd2;
  assign pop_valid_o = cnt_q != 2'd0;
  assign pop_data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/i2cmbe_back.sv]
// bus engine: phase sequencer, config registers and the result register
`default_nettype none

module i2cmbe_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [i2cmbe_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                                 pop_valid_i,
  input  i2cmbe_pkg::tick_t                    pop_data_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output i2cmbe_pkg::out_t                     out_data_o
);

  typedef enum logic [4:0] {
    PhIdle, PhS1, PhS2, PhP1, PhP2, PhP3,
    PhWSet, PhWHigh, PhWHold,
    PhRLow, PhRHigh, PhALow, PhAHigh,
    PhKLow, PhKHigh, PhKPoll
  } phase_e;

  phase_e                        phase_q, phase_d;
  logic [2:0]                    idx_q, idx_d, idx_n;
  logic [7:0]                    shift_q, shift_d;
  logic [i2cmbe_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [i2cmbe_pkg::ToW-1:0]    ackw_q, ackw_d, lim;
  logic                          scl_q, scl_d;
  logic                          sda_q, sda_d;
  logic                          ack_flag_q, ack_flag_d;
  logic [7:0]                    rx_q, rx_d;
  logic                          fail_q, fail_d;
  logic                          saf_q, saf_d;
  logic                          done;

  logic [i2cmbe_pkg::CfgW-1:0]   hold_cfg_q, bit_cfg_q;
  logic [i2cmbe_pkg::ToW-1:0]    to_cfg_q;
  logic [i2cmbe_pkg::CntW-1:0]   hold_len, bit_len;

  logic                          out_valid_q;
  i2cmbe_pkg::out_t              out_q;
  logic                          fire;

  assign fire        = pop_valid_i && (!out_valid_q || out_ready_i);
  assign pop_o       = fire;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hold_len = i2cmbe_pkg::load_len(hold_cfg_q);
  assign bit_len  = i2cmbe_pkg::load_len(bit_cfg_q);
  assign lim      = (to_cfg_q == '0) ? i2cmbe_pkg::ToW'(1) : to_cfg_q;
  assign idx_n    = idx_q + 3'd1;

  always_comb begin
    phase_d    = phase_q;
    idx_d      = idx_q;
    shift_d    = shift_q;
    cnt_d      = cnt_q;
    ackw_d     = ackw_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    ack_flag_d = ack_flag_q;
    rx_d       = rx_q;
    fail_d     = fail_q;
    saf_d      = saf_q;
    done       = 1'b0;

    if (phase_q == PhIdle) begin
      case (pop_data_i.cmd)
        i2cmbe_pkg::CmdStart: begin
          phase_d = PhS1; scl_d = 1'b1; sda_d = 1'b0; cnt_d = hold_len;
        end
        i2cmbe_pkg::CmdStop: begin
          saf_d   = 1'b0;
          phase_d = PhP1; scl_d = 1'b0; sda_d = 1'b1; cnt_d = hold_len;
        end
        i2cmbe_pkg::CmdWrite: begin
          shift_d = pop_data_i.tx_byte;
          idx_d   = 3'd0;
          phase_d = PhWSet; scl_d = 1'b0; sda_d = !pop_data_i.tx_byte[7];
          cnt_d   = bit_len;
        end
        i2cmbe_pkg::CmdRead: begin
          shift_d    = 8'd0;
          idx_d      = 3'd0;
          ack_flag_d = pop_data_i.send_ack;
          phase_d    = PhRLow; scl_d = 1'b0; sda_d = 1'b0; cnt_d = bit_len;
        end
        i2cmbe_pkg::CmdWait: begin
          ackw_d  = '0;
          phase_d = PhKLow; scl_d = 1'b0; sda_d = 1'b0; cnt_d = bit_len;
        end
        default: ;
      endcase
    end else if (phase_q == PhKPoll) begin
      if (!pop_data_i.sda_in) begin
        fail_d  = 1'b0;
        phase_d = PhIdle; scl_d = 1'b0; sda_d = 1'b0; cnt_d = '0; done = 1'b1;
      end else begin
        ackw_d = ackw_q + 1'b1;
        // timeout: send a stop and flag the failure at its end
        if (ackw_d >= lim) begin
          saf_d   = 1'b1;
          phase_d = PhP1; scl_d = 1'b0; sda_d = 1'b1; cnt_d = hold_len;
        end
      end
    end else if (cnt_q > i2cmbe_pkg::CntW'(1)) begin
      cnt_d = cnt_q - 1'b1;
    end else begin
      case (phase_q)
        PhS1: begin phase_d = PhS2; scl_d = 1'b1; sda_d = 1'b1; cnt_d = hold_len; end
        PhS2: begin
          phase_d = PhIdle; scl_d = 1'b0; sda_d = 1'b1; cnt_d = '0; done = 1'b1;
        end
        PhP1: begin phase_d = PhP2; scl_d = 1'b1; sda_d = 1'b1; cnt_d = hold_len; end
        PhP2: begin phase_d = PhP3; scl_d = 1'b1; sda_d = 1'b0; cnt_d = hold_len; end
        PhP3: begin
          if (saf_q) fail_d = 1'b1;
          saf_d   = 1'b0;
          phase_d = PhIdle; scl_d = 1'b1; sda_d = 1'b0; cnt_d = '0; done = 1'b1;
        end
        PhWSet:  begin phase_d = PhWHigh; scl_d = 1'b1; cnt_d = bit_len; end
        PhWHigh: begin phase_d = PhWHold; scl_d = 1'b0; cnt_d = bit_len; end
        PhWHold: begin
          if (idx_q == 3'd7) begin
            phase_d = PhIdle; scl_d = 1'b0; cnt_d = '0; done = 1'b1;
          end else begin
            idx_d   = idx_n;
            // msb first: bit 7 - n is bit ~n of the byte
            phase_d = PhWSet; scl_d = 1'b0; sda_d = !shift_q[~idx_n];
            cnt_d   = bit_len;
          end
        end
        PhRLow: begin phase_d = PhRHigh; scl_d = 1'b1; sda_d = 1'b0; cnt_d = bit_len; end
        PhRHigh: begin
          shift_d = {shift_q[6:0], pop_data_i.sda_in};
          if (idx_q == 3'd7) begin
            phase_d = PhALow; scl_d = 1'b0; sda_d = ack_flag_q; cnt_d = bit_len;
          end else begin
            idx_d   = idx_n;
            phase_d = PhRLow; scl_d = 1'b0; sda_d = 1'b0; cnt_d = bit_len;
          end
        end
        PhALow: begin phase_d = PhAHigh; scl_d = 1'b1; cnt_d = bit_len; end
        PhAHigh: begin
          rx_d    = shift_q;
          phase_d = PhIdle; scl_d = 1'b0; cnt_d = '0; done = 1'b1;
        end
        PhKLow: begin phase_d = PhKHigh; scl_d = 1'b1; sda_d = 1'b0; cnt_d = bit_len; end
        PhKHigh: begin
          phase_d = PhKPoll; scl_d = 1'b1; sda_d = 1'b0; cnt_d = i2cmbe_pkg::CntW'(1);
        end
        default: begin
          phase_d = PhIdle; cnt_d = '0; done = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhIdle;
      idx_q       <= 3'd0;
      shift_q     <= 8'd0;
      cnt_q       <= '0;
      ackw_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b0;
      ack_flag_q  <= 1'b0;
      rx_q        <= 8'd0;
      fail_q      <= 1'b0;
      saf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q    <= phase_d;
        idx_q      <= idx_d;
        shift_q    <= shift_d;
        cnt_q      <= cnt_d;
        ackw_q     <= ackw_d;
        scl_q      <= scl_d;
        sda_q      <= sda_d;
        ack_flag_q <= ack_flag_d;
        rx_q       <= rx_d;
        fail_q     <= fail_d;
        saf_q      <= saf_d;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cfg_q <= i2cmbe_pkg::HoldRst;
      bit_cfg_q  <= i2cmbe_pkg::BitRst;
      to_cfg_q   <= i2cmbe_pkg::TimeoutRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        i2cmbe_pkg::CfgStartStopHold: hold_cfg_q <= cfg_data_i;
        i2cmbe_pkg::CfgBitPhase:      bit_cfg_q  <= cfg_data_i;
        i2cmbe_pkg::CfgAckTimeout:    to_cfg_q   <= cfg_data_i[i2cmbe_pkg::ToW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.scl_level    <= scl_d;
      out_q.sda_pull_low <= sda_d;
      out_q.busy_res     <= phase_d != PhIdle;
      out_q.done_res     <= done;
      out_q.rx_byte      <= rx_d;
      out_q.ack_failed   <= fail_d;
    end
  end

endmodule

`default_nettype wire

[hdl/i2c_master_bit_engine.sv]
// top level: tick classifier, two-entry queue and i2c bus engine
// an accepted tick is written to the queue, then its result is registered in the engine's result register
// throughput: one tick per cycle, held back only by the result side stalling
// the engine's phase counter runs in ticks, not clock cycles
// reset: bus released (scl high, sda not pulled), engine idle, registers at defaults
// no memory clearing after reset: the block is ready on the first cycle
`default_nettype none

module i2c_master_bit_engine (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  i2cmbe_pkg::in_t                  in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output i2cmbe_pkg::out_t                 out_data_o,
  input  logic                             cfg_we_i,
  input  logic [i2cmbe_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [i2cmbe_pkg::CfgW-1:0]      cfg_data_i
);

  logic              q_full, push, pop_valid, pop;
  i2cmbe_pkg::tick_t push_data, pop_data;

  i2cmbe_front u_front (
    .in_data_i   (in_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  i2cmbe_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  i2cmbe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[hdl/i2cmbe_checker.sv]
// port-level checks for the i2c master bit engine, bound to the top level
`default_nettype none

module i2cmbe_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input i2cmbe_pkg::out_t out_data_o
);

  logic out_fire;
  logic prev_done_q;

  assign out_fire = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_done_q <= 1'b0;
    end else if (out_fire) begin
      prev_done_q <= out_data_o.done_res;
    end
  end

  // a completing tick always leaves the engine idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.done_res |-> !out_data_o.busy_res)
    else $error("done with busy still set");

  // no command can complete on the tick straight after another one
  a_no_double_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && prev_done_q |-> !out_data_o.done_res)
    else $error("two completions in a row");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result valid dropped before transaction");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine i2cmbe_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[verif/tb_i2c_master_bit_engine.sv]
// testbench for the i2c master bit engine: bus levels predicted tick by tick and checked
module tb_i2c_master_bit_engine;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Period       = 10;
  localparam int unsigned ResetCycles  = 10;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned EndCycles    = 8;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned RandomTicks  = 80;
  localparam int unsigned MaxReports   = 40;

  localparam logic [2:0] ReqNone   = 3'd0;
  localparam logic [2:0] ReqSpare6 = 3'd6;
  localparam logic [2:0] ReqSpare7 = 3'd7;

  // how sda_in is driven over the ticks of one command
  typedef enum int {SdaRand, SdaLow, SdaHigh, SdaMostlyHigh} sda_mode_e;

  typedef enum logic [3:0] {
    PIdle, PStartA, PStartB, PStopA, PStopB, PStopC,
    PWrLow, PWrHigh, PWrHold, PRdLow, PRdHigh, PAckLow, PAckHigh,
    PWaitLow, PWaitHigh, PWaitPoll
  } bus_phase_e;

  logic                            clk_i       = 1'b0;
  logic                            rst_ni      = 1'b0;
  logic                            in_valid_i  = 1'b0;
  logic                            in_ready_o;
  i2cmbe_pkg::in_t                 in_data_i   = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  i2cmbe_pkg::out_t                out_data_o;
  logic                            cfg_we_i    = 1'b0;
  logic [i2cmbe_pkg::CfgIdxW-1:0]  cfg_idx_i   = '0;
  logic [i2cmbe_pkg::CfgW-1:0]     cfg_data_i  = '0;

  i2c_master_bit_engine uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(Period / 2) clk_i = ~clk_i;

  // engine model state, reset values
  bus_phase_e  ph           = PIdle;
  logic [3:0]  bit_no       = '0;
  logic [7:0]  shreg        = '0;
  logic [15:0] ph_cnt       = '0;
  logic [7:0]  poll_cnt     = '0;
  logic        scl_q        = 1'b1;
  logic        sda_q        = 1'b0;
  logic        ack_out      = 1'b0;
  logic        timeout_stop = 1'b0;
  logic        done_q       = 1'b0;
  logic        ack_fail_q   = 1'b0;
  logic [7:0]  rx_q         = '0;
  logic [15:0] hold_cfg     = i2cmbe_pkg::HoldRst;
  logic [15:0] bit_cfg      = i2cmbe_pkg::BitRst;
  logic [7:0]  tmo_cfg      = i2cmbe_pkg::TimeoutRst;

  i2cmbe_pkg::out_t expected_bus_q[$];
  i2cmbe_pkg::in_t  tick_fifo[$];
  int unsigned ticks_queued    = 0;
  int unsigned ticks_sent      = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cmd_count       = 0;
  int unsigned read_count      = 0;
  int unsigned timeout_count   = 0;
  int unsigned configs_used    = 0;
  bit          tick_gaps_on    = 1'b1;
  bit          sink_stalls_on  = 1'b1;

  function automatic void enter_phase(bus_phase_e p, logic scl, logic sda, logic [15:0] len);
    ph     = p;
    scl_q  = scl;
    sda_q  = sda;
    ph_cnt = (len == '0) ? 16'd1 : len;
  endfunction

  function automatic void end_command(logic scl, logic sda);
    ph     = PIdle;
    scl_q  = scl;
    sda_q  = sda;
    ph_cnt = '0;
    done_q = 1'b1;
  endfunction

  // open drain: a zero data bit pulls sda low
  function automatic logic tx_pull();
    return ~shreg[3'd7 - bit_no[2:0]];
  endfunction

  function automatic void next_phase(logic sda_in);
    case (ph)
      PStartA: enter_phase(PStartB, 1'b1, 1'b1, hold_cfg);
      PStartB: end_command(1'b0, 1'b1);
      PStopA:  enter_phase(PStopB, 1'b1, 1'b1, hold_cfg);
      PStopB:  enter_phase(PStopC, 1'b1, 1'b0, hold_cfg);
      PStopC: begin
        if (timeout_stop) begin
          ack_fail_q = 1'b1;
          timeout_count++;
        end
        timeout_stop = 1'b0;
        end_command(1'b1, 1'b0);
      end
      PWrLow:  enter_phase(PWrHigh, 1'b1, sda_q, bit_cfg);
      PWrHigh: enter_phase(PWrHold, 1'b0, sda_q, bit_cfg);
      PWrHold: begin
        if (bit_no >= 4'd7) begin
          end_command(1'b0, sda_q);
        end else begin
          bit_no++;
          enter_phase(PWrLow, 1'b0, tx_pull(), bit_cfg);
        end
      end
      PRdLow: enter_phase(PRdHigh, 1'b1, 1'b0, bit_cfg);
      PRdHigh: begin
        shreg = {shreg[6:0], sda_in};
        if (bit_no >= 4'd7) begin
          enter_phase(PAckLow, 1'b0, ack_out, bit_cfg);
        end else begin
          bit_no++;
          enter_phase(PRdLow, 1'b0, 1'b0, bit_cfg);
        end
      end
      PAckLow: enter_phase(PAckHigh, 1'b1, sda_q, bit_cfg);
      PAckHigh: begin
        rx_q = shreg;
        end_command(1'b0, sda_q);
      end
      PWaitLow:  enter_phase(PWaitHigh, 1'b1, 1'b0, bit_cfg);
      PWaitHigh: enter_phase(PWaitPoll, 1'b1, 1'b0, 16'd1);
      default:   end_command(scl_q, sda_q);
    endcase
  endfunction

  // advance the engine by one tick and return the bus levels it then shows
  function automatic i2cmbe_pkg::out_t next_bus_levels(i2cmbe_pkg::in_t t);
    i2cmbe_pkg::out_t o;
    logic [7:0]       lim;
    done_q = 1'b0;
    if (ph == PIdle) begin
      case (t.req_type)
        i2cmbe_pkg::ReqStart: enter_phase(PStartA, 1'b1, 1'b0, hold_cfg);
        i2cmbe_pkg::ReqStop: begin
          timeout_stop = 1'b0;
          enter_phase(PStopA, 1'b0, 1'b1, hold_cfg);
        end
        i2cmbe_pkg::ReqWrite: begin
          shreg  = t.tx_byte;
          bit_no = '0;
          enter_phase(PWrLow, 1'b0, tx_pull(), bit_cfg);
        end
        i2cmbe_pkg::ReqRead: begin
          shreg   = '0;
          bit_no  = '0;
          ack_out = t.send_ack;
          read_count++;
          enter_phase(PRdLow, 1'b0, 1'b0, bit_cfg);
        end
        i2cmbe_pkg::ReqWait: begin
          poll_cnt = '0;
          enter_phase(PWaitLow, 1'b0, 1'b0, bit_cfg);
        end
        default: ;
      endcase
      if (ph != PIdle) cmd_count++;
    end else if (ph == PWaitPoll) begin
      if (!t.sda_in) begin
        ack_fail_q = 1'b0;
        end_command(1'b0, 1'b0);
      end else begin
        lim = (tmo_cfg == '0) ? 8'd1 : tmo_cfg;
        poll_cnt++;
        if (poll_cnt >= lim) begin
          timeout_stop = 1'b1;
          enter_phase(PStopA, 1'b0, 1'b1, hold_cfg);
        end
      end
    end else if (ph_cnt > 16'd1) begin
      ph_cnt--;
    end else begin
      next_phase(t.sda_in);
    end
    o.scl_level    = scl_q;
    o.sda_pull_low = sda_q;
    o.busy_res     = (ph != PIdle);
    o.done_res     = done_q;
    o.rx_byte      = rx_q;
    o.ack_failed   = ack_fail_q;
    return o;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin : tick_driver
    i2cmbe_pkg::in_t t;
    int unsigned     gap;
    forever begin
      @(negedge clk_i);
      if (tick_fifo.size() != 0) begin
        t   = tick_fifo.pop_front();
        gap = tick_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        in_valid_i <= 1'b1;
        in_data_i  <= t;
        do @(posedge clk_i); while (!in_ready_o);
        expected_bus_q.push_back(next_bus_levels(t));
        ticks_sent++;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  initial begin : result_sink
    int unsigned hold_off;
    forever begin
      @(negedge clk_i);
      if (sink_stalls_on && $urandom_range(0, 4) == 0) begin
        hold_off = pick_gap() + 1;
        out_ready_i <= 1'b0;
        repeat (hold_off) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    i2cmbe_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_bus_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports) $error("result transaction with no tick waiting for it");
      end else begin
        want = expected_bus_q.pop_front();
        check_field("scl_level", 8'(want.scl_level), 8'(out_data_o.scl_level));
        check_field("sda_pull_low", 8'(want.sda_pull_low), 8'(out_data_o.sda_pull_low));
        check_field("busy_res", 8'(want.busy_res), 8'(out_data_o.busy_res));
        check_field("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
        check_field("rx_byte", want.rx_byte, out_data_o.rx_byte);
        check_field("ack_failed", 8'(want.ack_failed), 8'(out_data_o.ack_failed));
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("FAIL i2c_master_bit_engine");
    $finish;
  end

  function automatic i2cmbe_pkg::in_t make_tick(logic [2:0] req, logic [7:0] tx, logic sack,
                                                logic sda);
    i2cmbe_pkg::in_t t;
    t.req_type = req;
    t.tx_byte  = tx;
    t.send_ack = sack;
    t.sda_in   = sda;
    return t;
  endfunction

  function automatic logic sda_bit(sda_mode_e mode);
    case (mode)
      SdaLow:        return 1'b0;
      SdaHigh:       return 1'b1;
      SdaMostlyHigh: return ($urandom_range(0, 3) != 0);
      default:       return 1'($urandom);
    endcase
  endfunction

  task automatic send_tick(i2cmbe_pkg::in_t t);
    int unsigned ticket;
    ticket       = ticks_queued + 1;
    ticks_queued = ticket;
    tick_fifo.push_back(t);
    wait (ticks_sent >= ticket);
  endtask

  // one command tick, then ticks with random (ignored) requests until the engine is idle
  task automatic run_command(logic [2:0] req, logic [7:0] tx, logic sack, sda_mode_e mode);
    send_tick(make_tick(req, tx, sack, sda_bit(mode)));
    while (ph != PIdle)
      send_tick(make_tick(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), sda_bit(mode)));
  endtask

  task automatic wait_results_drained();
    wait (results_checked == ticks_sent);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_config(logic [15:0] hold, logic [15:0] bitp, logic [7:0] tmo);
    wait_results_drained();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= i2cmbe_pkg::CfgStartStopHold;
    cfg_data_i <= hold;
    @(negedge clk_i);
    cfg_idx_i  <= i2cmbe_pkg::CfgBitPhase;
    cfg_data_i <= bitp;
    @(negedge clk_i);
    cfg_idx_i  <= i2cmbe_pkg::CfgAckTimeout;
    cfg_data_i <= 16'(tmo);
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    hold_cfg = hold;
    bit_cfg  = bitp;
    tmo_cfg  = tmo;
    configs_used++;
  endtask

  task automatic test_reset_defaults();
    run_command(ReqNone, 8'h00, 1'b0, SdaRand);
    run_command(ReqSpare6, 8'hFF, 1'b1, SdaHigh);
    run_command(ReqSpare7, 8'h3C, 1'b0, SdaLow);
    run_command(i2cmbe_pkg::ReqStart, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWrite, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWrite, 8'hFF, 1'b1, SdaRand);
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaLow);
    run_command(i2cmbe_pkg::ReqRead, 8'h00, 1'b1, SdaHigh);
    // slave never answers: full default timeout, then the engine sends a stop
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaHigh);
    run_command(i2cmbe_pkg::ReqStart, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaMostlyHigh);
    run_command(i2cmbe_pkg::ReqStop, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqStop, 8'h81, 1'b1, SdaRand);
  endtask

  // zero in every register behaves as one, the timeout included
  task automatic test_zero_lengths();
    set_config(16'd0, 16'd0, 8'd0);
    run_command(i2cmbe_pkg::ReqStart, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWrite, 8'h5A, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaHigh);
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaLow);
    run_command(i2cmbe_pkg::ReqRead, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqStop, 8'h00, 1'b0, SdaRand);
  endtask

  task automatic test_long_lengths();
    tick_gaps_on   = 1'b0;
    sink_stalls_on = 1'b0;
    set_config(16'd24, 16'd1, 8'd1);
    run_command(i2cmbe_pkg::ReqStart, 8'h00, 1'b0, SdaRand);
    run_command(i2cmbe_pkg::ReqWrite, 8'hC3, 1'b1, SdaRand);
    set_config(16'd1, 16'd9, 8'd40);
    run_command(i2cmbe_pkg::ReqWait, 8'h00, 1'b0, SdaHigh);
    tick_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  // start, address, ack, up to two data bytes, stop; now and then noise or a pause
  task automatic test_random_transactions();
    int unsigned first_tick;
    int unsigned n_trans;
    int unsigned n_bytes;
    first_tick = ticks_sent;
    n_trans    = 0;
    while (ticks_sent - first_tick < RandomTicks) begin
      if (n_trans % 4 == 0)
        set_config(16'($urandom_range(0, 3)), 16'($urandom_range(0, 2)),
                   8'($urandom_range(0, 6)));
      tick_gaps_on   = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 7) == 0) wait_results_drained();
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3))
          run_command(3'($urandom_range(0, 7)), 8'($urandom), 1'($urandom), SdaRand);
      end else begin
        run_command(i2cmbe_pkg::ReqStart, 8'($urandom), 1'($urandom), SdaRand);
        run_command(i2cmbe_pkg::ReqWrite, 8'($urandom), 1'($urandom), SdaRand);
        run_command(i2cmbe_pkg::ReqWait, 8'($urandom), 1'($urandom), SdaMostlyHigh);
        if (!ack_fail_q) begin
          n_bytes = $urandom_range(0, 2);
          repeat (n_bytes) begin
            if ($urandom_range(0, 1) != 0) begin
              run_command(i2cmbe_pkg::ReqWrite, 8'($urandom), 1'($urandom), SdaRand);
              run_command(i2cmbe_pkg::ReqWait, 8'($urandom), 1'($urandom), SdaMostlyHigh);
            end else begin
              run_command(i2cmbe_pkg::ReqRead, 8'($urandom), 1'($urandom), SdaRand);
            end
          end
          run_command(i2cmbe_pkg::ReqStop, 8'($urandom), 1'($urandom), SdaRand);
        end
      end
      n_trans++;
    end
    tick_gaps_on   = 1'b1;
    sink_stalls_on = 1'b1;
  endtask

  initial begin : main_seq
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_defaults();
    test_zero_lengths();
    test_long_lengths();
    test_random_transactions();
    wait (results_checked == ticks_sent);
    repeat (EndCycles) @(posedge clk_i);
    if (expected_bus_q.size() != 0) begin
      mismatches++;
      $error("%0d expected results never arrived", expected_bus_q.size());
    end
    $display("ticks: %0d sent, %0d results checked, %0d register settings",
             ticks_sent, results_checked, configs_used);
    $display("commands: %0d started, %0d reads, %0d ack timeouts, register values 0 to 250",
             cmd_count, read_count, timeout_count);
    if (mismatches == 0) $display("PASS i2c_master_bit_engine");
    else $display("FAIL i2c_master_bit_engine");
    $finish;
  end

endmodule
